// File: sv/satsc_pkg.sv
// Package for the set-associative tag store: geometry constants, operation codes,
// the request and result word types and the per-way entry layout.
// Has no dependencies of its own.
package satsc_pkg;

	localparam int SETS       = 64;
	localparam int WAYS       = 4;
	localparam int LINE_BYTES = 64;

	localparam int ADDR_W = 32;
	localparam int OFF_W  = $clog2(LINE_BYTES);
	localparam int SET_W  = $clog2(SETS);
	localparam int TAG_W  = ADDR_W - OFF_W - SET_W;
	localparam int WAY_W  = $clog2(WAYS);
	localparam int STAMP_W = 32;

	typedef enum logic [1:0] {
		OP_LOOKUP     = 2'd0,
		OP_INSTALL    = 2'd1,
		OP_MARK       = 2'd2,
		OP_INVALIDATE = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] address;
		logic [1:0]  way;
		logic        set_dirty;
		logic        set_pending_read;
		logic        set_pending_write;
		logic        touch;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  hit_way;
		logic        hit_dirty;
		logic        hit_pending_read;
		logic        hit_pending_write;
		logic        victim_found;
		logic [1:0]  victim_way;
		logic        victim_occupied;
		logic        victim_dirty;
		logic [31:0] victim_address;
	} result_t;

	// One way of a set as held in the tag memory.
	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic               dirty;
		logic               pend_rd;
		logic               pend_wr;
		logic [STAMP_W-1:0] stamp;
	} way_entry_t;

	typedef way_entry_t [WAYS-1:0] set_row_t;

endpackage

// File: sv/set_assoc_tag_store_clean_lru.sv
// Tag store of a set-associative cache with clean-first LRU replacement.
// Depends on satsc_pkg for geometry, operation codes and word types.
//
//  Channel   Handshake           Word             Direction
//  -------   ---------------     --------------   ---------
//  request   start / busy        req    (req_t)   in
//  result    done (strobe)       result (result_t) out
//
// Every request word makes one read-modify-write pass: in the accepting cycle the set
// row is read from the synchronous tag memory, and in the following cycle
// (busy high) the row is compared, the victim chosen and the row written
// back. The result word is shown for one cycle, with done high, in the cycle
// after that, during which the next request can already be accepted.
// So no new word is taken while busy is high; the throughput is set by the single
// read-modify-write pass through the tag memory.
// Reset clears the valid bits, the stamp counter and the handshake state at
// once; the tag memory itself holds no reset and needs no clearing pass.
// The receiver of results cannot stall the block.
module set_assoc_tag_store_clean_lru (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  satsc_pkg::req_t    req,
	output logic              done,
	output satsc_pkg::result_t result
);

	// Tag memory: one row per set, all ways side by side, so that a single
	// read gives everything the compare and the victim search need.
	satsc_pkg::set_row_t tag_ram [satsc_pkg::SETS];

	// Valid bits live in flip-flops so that reset can clear them at once.
	logic [satsc_pkg::SETS-1:0][satsc_pkg::WAYS-1:0] valid_q;

	logic                          busy_q;
	logic                          done_q;
	satsc_pkg::result_t            result_q;
	logic [satsc_pkg::STAMP_W-1:0] stamp_q;

	satsc_pkg::req_t               req_s1;
	satsc_pkg::set_row_t           rd_row_s1;

	logic                          accept;
	logic [satsc_pkg::SET_W-1:0]   set_in;
	logic [satsc_pkg::SET_W-1:0]   set_s1;
	logic [satsc_pkg::TAG_W-1:0]   tag_s1;
	logic [satsc_pkg::WAYS-1:0]    vld_s1;

	logic                          hit;
	logic [satsc_pkg::WAY_W-1:0]   hit_way;
	logic                          inv_found;
	logic                          clean_found;
	logic                          dirty_found;
	logic [satsc_pkg::WAY_W-1:0]   inv_way;
	logic [satsc_pkg::WAY_W-1:0]   clean_way;
	logic [satsc_pkg::WAY_W-1:0]   dirty_way;
	logic [satsc_pkg::STAMP_W-1:0] clean_stamp;
	logic [satsc_pkg::STAMP_W-1:0] dirty_stamp;
	logic                          vic_found;
	logic [satsc_pkg::WAY_W-1:0]   vic_way;
	logic                          vic_occ;

	logic [satsc_pkg::WAY_W-1:0]   tgt_way;
	logic                          tgt_ok;
	satsc_pkg::set_row_t           new_row;
	logic [satsc_pkg::WAYS-1:0]    new_vld;
	satsc_pkg::result_t            res_d;

	assign accept = start && !busy_q;
	assign set_in = req.address[satsc_pkg::OFF_W +: satsc_pkg::SET_W];
	assign set_s1 = req_s1.address[satsc_pkg::OFF_W +: satsc_pkg::SET_W];
	assign tag_s1 = req_s1.address[satsc_pkg::ADDR_W-1 -: satsc_pkg::TAG_W];
	assign vld_s1 = valid_q[set_s1];

	// Hit search and victim choice over the ways of the set. The lowest
	// matching way reports the hit; among equal stamps the lowest way wins.
	always_comb begin
		hit         = 1'b0;
		hit_way     = '0;
		inv_found   = 1'b0;
		clean_found = 1'b0;
		dirty_found = 1'b0;
		inv_way     = '0;
		clean_way   = '0;
		dirty_way   = '0;
		clean_stamp = '0;
		dirty_stamp = '0;
		for (int i = 0; i < satsc_pkg::WAYS; i++) begin
			if (!vld_s1[i]) begin
				if (!inv_found) begin
					inv_found = 1'b1;
					inv_way   = satsc_pkg::WAY_W'(i);
				end
			end else begin
				if (!hit && rd_row_s1[i].tag == tag_s1) begin
					hit     = 1'b1;
					hit_way = satsc_pkg::WAY_W'(i);
				end
				if (!(rd_row_s1[i].pend_rd || rd_row_s1[i].pend_wr)) begin
					if (!rd_row_s1[i].dirty) begin
						if (!clean_found || rd_row_s1[i].stamp < clean_stamp) begin
							clean_found = 1'b1;
							clean_way   = satsc_pkg::WAY_W'(i);
							clean_stamp = rd_row_s1[i].stamp;
						end
					end else begin
						if (!dirty_found || rd_row_s1[i].stamp < dirty_stamp) begin
							dirty_found = 1'b1;
							dirty_way   = satsc_pkg::WAY_W'(i);
							dirty_stamp = rd_row_s1[i].stamp;
						end
					end
				end
			end
		end
	end

	always_comb begin
		priority if (inv_found) begin
			vic_way = inv_way;
		end else if (clean_found) begin
			vic_way = clean_way;
		end else if (dirty_found) begin
			vic_way = dirty_way;
		end else begin
			vic_way = '0;
		end
	end

	assign vic_found = inv_found || clean_found || dirty_found;
	assign vic_occ   = vic_found && !inv_found;

	// The result describes the set as it stood before this word's update.
	always_comb begin
		res_d                   = '0;
		res_d.hit               = hit;
		res_d.victim_found      = vic_found;
		res_d.victim_way        = 2'(vic_way);
		res_d.victim_occupied   = vic_occ;
		if (hit) begin
			res_d.hit_way           = 2'(hit_way);
			res_d.hit_dirty         = rd_row_s1[hit_way].dirty;
			res_d.hit_pending_read  = rd_row_s1[hit_way].pend_rd;
			res_d.hit_pending_write = rd_row_s1[hit_way].pend_wr;
		end
		if (vic_occ) begin
			res_d.victim_dirty   = rd_row_s1[vic_way].dirty;
			res_d.victim_address = {rd_row_s1[vic_way].tag, set_s1,
				{satsc_pkg::OFF_W{1'b0}}};
		end
	end

	// Row update. A target way beyond the set leaves everything unchanged.
	assign tgt_way = satsc_pkg::WAY_W'(req_s1.way);
	assign tgt_ok  = 32'(req_s1.way) < satsc_pkg::WAYS;

	always_comb begin
		new_row = rd_row_s1;
		new_vld = vld_s1;
		unique case (req_s1.op)
			satsc_pkg::OP_LOOKUP: begin
				if (hit && req_s1.touch) begin
					new_row[hit_way].stamp = stamp_q;
				end
			end
			satsc_pkg::OP_INSTALL: begin
				if (tgt_ok) begin
					new_row[tgt_way].tag     = tag_s1;
					new_row[tgt_way].dirty   = req_s1.set_dirty;
					new_row[tgt_way].pend_rd = req_s1.set_pending_read;
					new_row[tgt_way].pend_wr = req_s1.set_pending_write;
					new_row[tgt_way].stamp   = stamp_q;
					new_vld[tgt_way]         = 1'b1;
				end
			end
			satsc_pkg::OP_MARK: begin
				if (tgt_ok) begin
					new_row[tgt_way].dirty   = req_s1.set_dirty;
					new_row[tgt_way].pend_rd = req_s1.set_pending_read;
					new_row[tgt_way].pend_wr = req_s1.set_pending_write;
					if (req_s1.touch) begin
						new_row[tgt_way].stamp = stamp_q;
					end
				end
			end
			satsc_pkg::OP_INVALIDATE: begin
				if (tgt_ok) begin
					new_vld[tgt_way] = 1'b0;
				end
			end
			default: begin
				new_row = rd_row_s1;
			end
		endcase
	end

	// Synchronous tag memory: read on accept, written back in the busy cycle.
	// The two never fall in the same cycle, so no forwarding is required.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= tag_ram[set_in];
			req_s1    <= req;
		end
		if (busy_q) begin
			tag_ram[set_s1] <= new_row;
		end
		if (busy_q) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			stamp_q <= '0;
			valid_q <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				valid_q[set_s1] <= new_vld;
				stamp_q         <= stamp_q + 1'b1;
			end
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_one_busy_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held for more than one cycle");

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> done_q)
		else $error("result strobe missing after the work cycle");

	a_done_only_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result strobe without a preceding work cycle");

	a_stamp_per_word: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> stamp_q == $past(stamp_q) + 1'b1)
		else $error("stamp counter did not advance for a word");

	a_occupied_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.victim_occupied |-> result_q.victim_found)
		else $error("occupied victim reported without a victim");
`endif

endmodule

// File: tb/sv/set_assoc_tag_store_clean_lru_checker.sv
`timescale 1ns / 100ps
// Checker for the set-associative tag store. It keeps its own copy of the tags,
// marks and use stamps, predicts every result word and compares it field by field.
// Depends on satsc_pkg for the geometry, the operation codes and the word types.
module set_assoc_tag_store_clean_lru_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  satsc_pkg::req_t    req,
	input  logic               done,
	input  satsc_pkg::result_t result,
	output int                 mismatches,
	output int                 words_due,
	output int                 words_checked,
	output int                 hits_seen,
	output int                 stalls_seen,
	output int                 dirty_victims_seen
);
	import satsc_pkg::*;

	localparam int ENTRIES   = SETS * WAYS;
	localparam int DUE_DEPTH = 8;

	// Mirror of the tag memory, one entry per way of every set.
	logic [TAG_W-1:0]   line_tags   [ENTRIES];
	logic               way_valid   [ENTRIES];
	logic               way_dirty   [ENTRIES];
	logic               way_pend_rd [ENTRIES];
	logic               way_pend_wr [ENTRIES];
	logic [STAMP_W-1:0] way_stamps  [ENTRIES];
	logic [STAMP_W-1:0] access_clock;

	// Predicted words waiting for their strobe, kept in arrival order.
	result_t    reports_due [DUE_DEPTH];
	logic [2:0] due_wr;
	logic [2:0] due_rd;
	int         due_count;

	initial begin
		mismatches = 0;
		words_due = 0;
		words_checked = 0;
		hits_seen = 0;
		stalls_seen = 0;
		dirty_victims_seen = 0;
		access_clock = '0;
		due_wr = '0;
		due_rd = '0;
		due_count = 0;
		foreach (way_valid[i])
			way_valid[i] = 1'b0;
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("%0t ns: %s is %0h, %0h was due", $time, field, got, want);
		mismatches++;
	endtask

	// Reads the set as it stands, works out the hit and the victim, then applies
	// the operation and advances the access clock.
	function automatic result_t access_tag_set(input req_t w);
		result_t r;
		logic [SET_W-1:0] set_idx;
		logic [TAG_W-1:0] tag;
		int base, e, ve, he;
		int hway, inv_way, clean_way, dirty_way, vway;
		bit hit, inv_found, clean_found, dirty_found;
		set_idx = w.address[OFF_W +: SET_W];
		tag = w.address[ADDR_W-1 -: TAG_W];
		base = int'(set_idx) * WAYS;
		hit = 1'b0;
		inv_found = 1'b0;
		clean_found = 1'b0;
		dirty_found = 1'b0;
		hway = 0;
		inv_way = 0;
		clean_way = 0;
		dirty_way = 0;
		for (int i = 0; i < WAYS; i++) begin
			e = base + i;
			if (!way_valid[e]) begin
				if (!inv_found) begin
					inv_found = 1'b1;
					inv_way = i;
				end
			end else begin
				if (!hit && line_tags[e] == tag) begin
					hit = 1'b1;
					hway = i;
				end
				// A way with an access in flight can never be evicted.
				if (!way_pend_rd[e] && !way_pend_wr[e]) begin
					if (!way_dirty[e]) begin
						if (!clean_found || way_stamps[e] < way_stamps[base + clean_way]) begin
							clean_found = 1'b1;
							clean_way = i;
						end
					end else begin
						if (!dirty_found || way_stamps[e] < way_stamps[base + dirty_way]) begin
							dirty_found = 1'b1;
							dirty_way = i;
						end
					end
				end
			end
		end

		r = '0;
		he = base + hway;
		if (hit) begin
			r.hit = 1'b1;
			r.hit_way = 2'(hway);
			r.hit_dirty = way_dirty[he];
			r.hit_pending_read = way_pend_rd[he];
			r.hit_pending_write = way_pend_wr[he];
		end
		vway = inv_found ? inv_way : (clean_found ? clean_way : (dirty_found ? dirty_way : 0));
		ve = base + vway;
		r.victim_found = inv_found || clean_found || dirty_found;
		r.victim_way = 2'(vway);
		r.victim_occupied = r.victim_found && !inv_found;
		if (r.victim_occupied) begin
			r.victim_dirty = way_dirty[ve];
			r.victim_address = {line_tags[ve], set_idx, {OFF_W{1'b0}}};
		end

		e = base + int'(w.way);
		case (w.op)
			OP_LOOKUP: begin
				if (hit && w.touch)
					way_stamps[he] = access_clock;
			end
			OP_INSTALL: begin
				if (int'(w.way) < WAYS) begin
					line_tags[e] = tag;
					way_valid[e] = 1'b1;
					way_dirty[e] = w.set_dirty;
					way_pend_rd[e] = w.set_pending_read;
					way_pend_wr[e] = w.set_pending_write;
					way_stamps[e] = access_clock;
				end
			end
			OP_MARK: begin
				if (int'(w.way) < WAYS) begin
					way_dirty[e] = w.set_dirty;
					way_pend_rd[e] = w.set_pending_read;
					way_pend_wr[e] = w.set_pending_write;
					if (w.touch)
						way_stamps[e] = access_clock;
				end
			end
			OP_INVALIDATE: begin
				if (int'(w.way) < WAYS)
					way_valid[e] = 1'b0;
			end
		endcase
		access_clock = access_clock + 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (way_valid[i])
				way_valid[i] = 1'b0;
			access_clock = '0;
			due_wr = '0;
			due_rd = '0;
			due_count = 0;
			words_due = 0;
		end else begin
			if (start && !busy) begin
				want = access_tag_set(req);
				if (due_count == DUE_DEPTH) begin
					report_mismatch("request word taken with too many results outstanding",
						32'(due_count), 0);
				end else begin
					reports_due[due_wr] = want;
					due_wr = due_wr + 1'b1;
					due_count++;
				end
				if (want.hit)
					hits_seen++;
				if (!want.victim_found)
					stalls_seen++;
				if (want.victim_dirty)
					dirty_victims_seen++;
			end
			if (done) begin
				if (due_count == 0) begin
					report_mismatch("result word with nothing outstanding", 32'(result.hit), 0);
				end else begin
					want = reports_due[due_rd];
					due_rd = due_rd + 1'b1;
					due_count--;
					words_checked++;
					if (result.hit !== want.hit)
						report_mismatch("hit", 32'(result.hit), 32'(want.hit));
					if (result.hit_way !== want.hit_way)
						report_mismatch("hit_way", 32'(result.hit_way), 32'(want.hit_way));
					if (result.hit_dirty !== want.hit_dirty)
						report_mismatch("hit_dirty", 32'(result.hit_dirty), 32'(want.hit_dirty));
					if (result.hit_pending_read !== want.hit_pending_read)
						report_mismatch("hit_pending_read", 32'(result.hit_pending_read),
							32'(want.hit_pending_read));
					if (result.hit_pending_write !== want.hit_pending_write)
						report_mismatch("hit_pending_write", 32'(result.hit_pending_write),
							32'(want.hit_pending_write));
					if (result.victim_found !== want.victim_found)
						report_mismatch("victim_found", 32'(result.victim_found),
							32'(want.victim_found));
					if (result.victim_way !== want.victim_way)
						report_mismatch("victim_way", 32'(result.victim_way), 32'(want.victim_way));
					if (result.victim_occupied !== want.victim_occupied)
						report_mismatch("victim_occupied", 32'(result.victim_occupied),
							32'(want.victim_occupied));
					if (result.victim_dirty !== want.victim_dirty)
						report_mismatch("victim_dirty", 32'(result.victim_dirty),
							32'(want.victim_dirty));
					if (result.victim_address !== want.victim_address)
						report_mismatch("victim_address", result.victim_address,
							want.victim_address);
				end
			end
			words_due = due_count;
		end
	end

endmodule

// File: tb/sv/set_assoc_tag_store_clean_lru_test.sv
`timescale 1ns / 100ps
// Top of the tag store testbench: clock, reset, request stimulus and verdict.
// Depends on satsc_pkg, the tag store itself and the checker module beside it.
module set_assoc_tag_store_clean_lru_test;
	import satsc_pkg::*;

	// A watchdog ends the run after this many cycles in which no word moved in
	// either direction. A correct block never comes near it.
	localparam int QUIET_LIMIT = 400;

	localparam logic [TAG_W-1:0]  TOP_TAG   = '1;
	localparam logic [SET_W-1:0]  TOP_SET   = '1;
	localparam logic [OFF_W-1:0]  LAST_BYTE = '1;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	req_t    req = '0;
	logic    busy;
	logic    done;
	result_t result;

	int mismatches, words_due, words_checked;
	int hits_seen, stalls_seen, dirty_victims_seen;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	set_assoc_tag_store_clean_lru dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	set_assoc_tag_store_clean_lru_checker tag_store_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.req                (req),
		.done               (done),
		.result             (result),
		.mismatches         (mismatches),
		.words_due          (words_due),
		.words_checked      (words_checked),
		.hits_seen          (hits_seen),
		.stalls_seen        (stalls_seen),
		.dirty_victims_seen (dirty_victims_seen)
	);

	// Builds a request word from its parts; marks packs dirty, pending read,
	// pending write and touch, in that order from the top bit down.
	function automatic req_t word_of(input op_t op, input logic [TAG_W-1:0] tag,
			input logic [SET_W-1:0] set_idx, input logic [OFF_W-1:0] offs,
			input logic [1:0] way, input logic [3:0] marks);
		req_t w;
		w.op = op;
		w.address = {tag, set_idx, offs};
		w.way = way;
		{w.set_dirty, w.set_pending_read, w.set_pending_write, w.touch} = marks;
		return w;
	endfunction

	// Random request words in three mixes. Mix 0 works a handful of sets with a
	// small pool of tags, so that sets fill up, hits are common and the
	// replacement order gets exercised. Mix 1 crowds two sets and sets the
	// pending marks often, so that whole sets become unevictable. Mix 2 is the
	// noise: addresses spread over the whole space, some of them fully random.
	function automatic req_t random_word(input int mix);
		req_t w;
		logic [TAG_W-1:0] t;
		logic [SET_W-1:0] s;
		int pick;
		int pend_pct;
		w = '0;
		pick = $urandom_range(99);
		if (pick < 40)
			w.op = OP_LOOKUP;
		else if (pick < 65)
			w.op = OP_INSTALL;
		else if (pick < 85)
			w.op = OP_MARK;
		else
			w.op = OP_INVALIDATE;
		case (mix)
			0: begin
				s = SET_W'($urandom_range(7));
				t = TAG_W'($urandom_range(9));
			end
			1: begin
				s = SET_W'($urandom_range(1));
				t = TAG_W'($urandom_range(5));
			end
			default: begin
				s = SET_W'($urandom);
				t = ($urandom_range(3) == 0) ? TAG_W'($urandom_range(3)) : TAG_W'($urandom);
			end
		endcase
		// The all-ones tag now and then, so the top address bits see traffic too.
		if ($urandom_range(19) == 0)
			t = TOP_TAG;
		w.address = {t, s, OFF_W'($urandom)};
		if (mix == 2 && $urandom_range(3) == 0)
			w.address = $urandom;
		w.way = 2'($urandom);
		w.set_dirty = 1'($urandom);
		pend_pct = (mix == 1) ? 45 : 20;
		w.set_pending_read = ($urandom_range(99) < pend_pct);
		w.set_pending_write = ($urandom_range(99) < pend_pct);
		w.touch = 1'($urandom);
		return w;
	endfunction

	// Presents one word and returns at the edge that accepts it. Start is left
	// high, so back-to-back words keep it high without a glitch; a random gap
	// lowers it first. The gap lengths vary, so that idle cycles land both on
	// the busy cycle and on the cycle where the block could take a new word.
	task automatic send_word(input req_t w, input bit may_idle);
		int gap;
		gap = 0;
		if (may_idle && $urandom_range(99) < 10)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (busy);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("set_assoc_tag_store_clean_lru_test: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Set 0 is filled with one way of each kind (clean,
		// dirty, pending read, pending write) and then walked through the victim
		// preferences: clean before dirty, oldest first, and none at all once
		// every valid way has an access in flight. The very first word also looks
		// up address zero in an empty set.
		send_word(word_of(OP_LOOKUP,  '0,      '0, '0, 2'd0, 4'b0000), 1'b1);
		send_word(word_of(OP_INSTALL, '0,      '0, '0, 2'd0, 4'b0000), 1'b1);
		send_word(word_of(OP_INSTALL, TOP_TAG, '0, '0, 2'd1, 4'b1000), 1'b1);
		send_word(word_of(OP_INSTALL, 20'd1,   '0, '0, 2'd2, 4'b0100), 1'b1);
		send_word(word_of(OP_INSTALL, 20'd2,   '0, '0, 2'd3, 4'b0010), 1'b1);
		// A touching hit on the dirty way; the clean way 0 is still the victim.
		send_word(word_of(OP_LOOKUP,  TOP_TAG, '0, '0, 2'd0, 4'b0001), 1'b1);
		// Address all ones: top tag in the top set, which is still empty.
		send_word(word_of(OP_LOOKUP,  TOP_TAG, TOP_SET, LAST_BYTE, 2'd0, 4'b0000), 1'b1);
		// Way 0 turns dirty and younger, so the older dirty way 1 becomes victim.
		send_word(word_of(OP_MARK,    '0,      '0, '0, 2'd0, 4'b1001), 1'b1);
		send_word(word_of(OP_LOOKUP,  '0,      '0, '0, 2'd0, 4'b0000), 1'b1);
		// Pending accesses on every remaining candidate leave no victim.
		send_word(word_of(OP_MARK,    '0,      '0, '0, 2'd0, 4'b1110), 1'b1);
		send_word(word_of(OP_MARK,    '0,      '0, '0, 2'd1, 4'b1100), 1'b1);
		send_word(word_of(OP_LOOKUP,  20'd1,   '0, '0, 2'd0, 4'b0000), 1'b1);

		// A mark update on an invalid way must leave it invalid and free.
		send_word(word_of(OP_MARK,    '0,      TOP_SET, '0, 2'd2, 4'b1111), 1'b1);
		send_word(word_of(OP_LOOKUP,  TOP_TAG, TOP_SET, '0, 2'd0, 4'b0000), 1'b1);
		// The same tag installed twice: the lower way reports the hit. Touch on
		// install and on invalidate must change nothing extra.
		send_word(word_of(OP_INSTALL, TOP_TAG, TOP_SET, '0, 2'd0, 4'b1001), 1'b1);
		send_word(word_of(OP_INSTALL, TOP_TAG, TOP_SET, '0, 2'd1, 4'b0000), 1'b1);
		send_word(word_of(OP_LOOKUP,  TOP_TAG, TOP_SET, LAST_BYTE, 2'd0, 4'b0000), 1'b1);
		send_word(word_of(OP_INVALIDATE, '0,   TOP_SET, '0, 2'd0, 4'b0001), 1'b1);
		send_word(word_of(OP_LOOKUP,  TOP_TAG, TOP_SET, LAST_BYTE, 2'd0, 4'b0000), 1'b1);
		// Fill the top set; the oldest clean way then gives the highest possible
		// victim address.
		send_word(word_of(OP_INSTALL, 20'd3,   TOP_SET, '0, 2'd0, 4'b0000), 1'b1);
		send_word(word_of(OP_INSTALL, 20'd4,   TOP_SET, '0, 2'd2, 4'b0000), 1'b1);
		send_word(word_of(OP_INSTALL, 20'd6,   TOP_SET, '0, 2'd3, 4'b1000), 1'b1);
		send_word(word_of(OP_LOOKUP,  20'd7,   TOP_SET, '0, 2'd0, 4'b0000), 1'b1);
		// Clearing the marks of way 0 without a touch makes it clean and free again.
		send_word(word_of(OP_MARK,    '0,      '0, '0, 2'd0, 4'b0000), 1'b1);
		send_word(word_of(OP_LOOKUP,  20'd9,   '0, '0, 2'd0, 4'b0000), 1'b1);

		// Random part. The crowded mix runs without any idle cycles, giving a
		// long stretch of back-to-back words at the full rate.
		for (int n = 0; n < 600; n++)
			send_word(random_word(0), 1'b1);
		for (int n = 0; n < 600; n++)
			send_word(random_word(1), 1'b0);
		for (int n = 0; n < 500; n++)
			send_word(random_word(2), 1'b1);
		start <= 1'b0;

		// Let the checker take in the last word before looking at what is due,
		// then allow the last pass a little slack.
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Checked %0d result words: %0d hits, %0d with no evictable way,",
			words_checked, hits_seen, stalls_seen);
		$display("and %0d offering a dirty victim for write-back.", dirty_victims_seen);
		if (mismatches == 0) begin
			$display("set_assoc_tag_store_clean_lru_test: clean");
		end else begin
			$display("set_assoc_tag_store_clean_lru_test: errors");
		end
		$finish;
	end

endmodule

// File: set_assoc_tag_store_clean_lru.f
sv/satsc_pkg.sv
sv/set_assoc_tag_store_clean_lru.sv
tb/sv/set_assoc_tag_store_clean_lru_checker.sv
tb/sv/set_assoc_tag_store_clean_lru_test.sv
